// File: src/srs_pkg.sv
// shared constants, types and helpers for the streaming find-and-replace core
package srs_pkg;

   localparam int PATTERN_MAX_DEF = 8;
   localparam int REPLACEMENT_MAX = 8;
   localparam int LEN_CAP = 8;
   localparam int BYTE_W = 8;
   localparam int WORD_W = 64;
   localparam int COUNT_W = 16;
   localparam int LEN_W = 4;
   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 64;

   localparam logic [CSR_AW-1:0] CSR_PATTERN_BYTES = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_PATTERN_LENGTH = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_REPLACEMENT_BYTES = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_REPLACEMENT_LENGTH = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_LIMIT_COUNT = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_LIMIT_ENABLE = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_ANCHORED_MODE = 3'd6;

   typedef struct packed {
      logic load;
      logic shift;
      logic clear;
   } win_ctrl_type;

   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len, input int cap);
      logic [LEN_W-1:0] r;
      r = len;
      if (int'(r) > LEN_CAP) begin
         r = LEN_W'(LEN_CAP);
      end
      if (int'(r) > cap) begin
         r = LEN_W'(cap);
      end
      return r;
   endfunction

endpackage

// File: src/srs_cell.sv
// one window cell: holds a byte, takes its neighbor's byte on shift, compares to its pattern byte
module srs_cell (
   input  logic       clock,
   input  logic       load,
   input  logic       shift,
   input  logic [7:0] new_byte,
   input  logic [7:0] near_byte,
   input  logic [7:0] pattern_byte,
   output logic [7:0] cell_byte,
   output logic       match
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (load) begin
         byte_in = new_byte;
      end else if (shift) begin
         byte_in = near_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;
   assign match = (byte_ff == pattern_byte);

endmodule

// File: src/srs_window.sv
// match window: a row of cells shifting toward the head, with its fill count
module srs_window #(
   parameter int DEPTH = srs_pkg::PATTERN_MAX_DEF,
   localparam int FILL_W = $clog2(DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  srs_pkg::win_ctrl_type      ctrl,
   input  logic [7:0]                 new_byte,
   input  logic [srs_pkg::WORD_W-1:0] pattern_bytes,
   output logic [FILL_W-1:0]          fill,
   output logic [7:0]                 head_byte,
   output logic                       all_match
);

   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [7:0]        cell_bytes [DEPTH];
   logic [DEPTH-1:0]  cell_ok;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [7:0] near;
      logic       match;
      if (i == DEPTH - 1) begin : g_tail
         assign near = '0;
      end else begin : g_mid
         assign near = cell_bytes[i+1];
      end
      srs_cell u_cell (
         .clock        (clock),
         .load         (ctrl.load && (fill_ff == FILL_W'(i))),
         .shift        (ctrl.shift),
         .new_byte     (new_byte),
         .near_byte    (near),
         .pattern_byte (pattern_bytes[(i % 8) * 8 +: 8]),
         .cell_byte    (cell_bytes[i]),
         .match        (match)
      );
      assign cell_ok[i] = (fill_ff <= FILL_W'(i)) || match;
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctrl.clear) begin
         fill_in = '0;
      end else if (ctrl.load) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (ctrl.shift) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign fill = fill_ff;
   assign head_byte = cell_bytes[0];
   assign all_match = &cell_ok;

endmodule

// File: src/substring_replace_stream_core.sv
// top level of the streaming find-and-replace core
// Source bytes enter on req_ one at a time, req_tlast marking the last byte of a string.
// While replacing is on, each accepted byte is appended to a window of PATTERN_MAX cells that
// shifts toward its head; each step decides whether the window matches the pattern in full, is
// still a prefix, or must pass its oldest byte out, and in anchored mode a mismatch flushes the
// window and stops replacing. Replacement bytes are queued one per cycle. Every byte a source
// byte causes is gathered in a 16-entry result queue and then sent on rsp_, one transfer per
// cycle while rsp_tready allows, so that the count and the end flags are final on each. Source
// bytes are handled one at a time, as the single shifting window and the single rsp_ port
// demand; each passes the step states in order: idle, then scan or flush, replace after a
// match, then finish and drain. The next byte is taken once the last transfer of the previous
// one has been put on rsp_, even while that transfer still waits for rsp_tready.
// A string end that causes no byte still gives one transfer with tuser byte_valid low.
// Configuration is to be written on csr_ only while no byte is in progress; the core does not enforce this.
module substring_replace_stream_core #(
   parameter int PATTERN_MAX = srs_pkg::PATTERN_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] in_byte
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,   // [7:0] out_byte, [23:8] replacements
   output logic                       rsp_tlast,
   output logic [1:0]                 rsp_tuser,   // [0] byte_valid, [1] string_done
   input  logic                       csr_wen,
   input  logic [srs_pkg::CSR_AW-1:0] csr_index,
   input  logic [srs_pkg::CSR_DW-1:0] csr_wdata
);

   localparam int FILL_W = $clog2(PATTERN_MAX + 1);
   localparam int QAW = srs_pkg::QUEUE_AW;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_REPL   = 6'b000100,
      ST_FLUSH  = 6'b001000,
      ST_FINISH = 6'b010000,
      ST_DRAIN  = 6'b100000
   } state_type;

   logic [srs_pkg::WORD_W-1:0]  pattern_bytes_ff;
   logic [srs_pkg::LEN_W-1:0]   pattern_length_ff;
   logic [srs_pkg::WORD_W-1:0]  replacement_bytes_ff;
   logic [srs_pkg::LEN_W-1:0]   replacement_length_ff;
   logic [srs_pkg::COUNT_W-1:0] limit_count_ff;
   logic                        limit_enable_ff;
   logic                        anchored_mode_ff;

   state_type                   state_ff, state_in;
   logic [srs_pkg::COUNT_W-1:0] match_count_ff, match_count_in;
   logic                        stopped_ff, stopped_in;
   logic [srs_pkg::COUNT_W-1:0] snap_ff, snap_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        eos_ff, eos_in;
   logic                        tail_ff, tail_in;
   logic [QAW:0]                wr_ff, wr_in;
   logic [QAW:0]                rd_ff, rd_in;
   logic [srs_pkg::LEN_W-1:0]   rcnt_ff, rcnt_in;
   logic [7:0]                  queue_ff [srs_pkg::QUEUE_DEPTH];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_bvalid_ff, rsp_bvalid_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_done_ff, rsp_done_in;
   logic [srs_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   srs_pkg::win_ctrl_type       win_ctrl;
   logic [FILL_W-1:0]           fill;
   logic [7:0]                  head_byte;
   logic                        all_match;
   logic                        push_en;
   logic [7:0]                  push_byte;

   logic [srs_pkg::LEN_W-1:0]   plen;
   logic [srs_pkg::LEN_W-1:0]   rlen;
   logic                        limit_hit;
   logic [srs_pkg::COUNT_W-1:0] count_inc;
   logic                        hit_after;
   logic                        out_free;
   logic                        fill_zero;
   logic                        fill_full;
   logic                        q_last;

   assign plen = srs_pkg::eff_len(pattern_length_ff, PATTERN_MAX);
   assign rlen = srs_pkg::eff_len(replacement_length_ff, srs_pkg::REPLACEMENT_MAX);
   assign limit_hit = limit_enable_ff && (match_count_ff >= limit_count_ff);
   assign count_inc = (match_count_ff == '1) ? match_count_ff
                                             : match_count_ff + srs_pkg::COUNT_W'(1);
   assign hit_after = limit_enable_ff && (count_inc >= limit_count_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fill_zero = (fill == '0);
   assign fill_full = (int'(fill) == PATTERN_MAX);
   assign q_last = (rd_ff + (QAW + 1)'(1)) == wr_ff;

   srs_window #(
      .DEPTH (PATTERN_MAX)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (win_ctrl),
      .new_byte      (req_tdata),
      .pattern_bytes (pattern_bytes_ff),
      .fill          (fill),
      .head_byte     (head_byte),
      .all_match     (all_match)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= '0;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
         limit_count_ff        <= '0;
         limit_enable_ff       <= 1'b0;
         anchored_mode_ff      <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            srs_pkg::CSR_PATTERN_BYTES: begin
               pattern_bytes_ff <= csr_wdata;
            end
            srs_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_wdata[srs_pkg::LEN_W-1:0];
            end
            srs_pkg::CSR_REPLACEMENT_BYTES: begin
               replacement_bytes_ff <= csr_wdata;
            end
            srs_pkg::CSR_REPLACEMENT_LENGTH: begin
               replacement_length_ff <= csr_wdata[srs_pkg::LEN_W-1:0];
            end
            srs_pkg::CSR_LIMIT_COUNT: begin
               limit_count_ff <= csr_wdata[srs_pkg::COUNT_W-1:0];
            end
            srs_pkg::CSR_LIMIT_ENABLE: begin
               limit_enable_ff <= csr_wdata[0];
            end
            srs_pkg::CSR_ANCHORED_MODE: begin
               anchored_mode_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // step sequencer
   always_comb begin
      state_in       = state_ff;
      match_count_in = match_count_ff;
      stopped_in     = stopped_ff;
      snap_in        = snap_ff;
      byte_in        = byte_ff;
      eos_in         = eos_ff;
      tail_in        = tail_ff;
      rd_in          = rd_ff;
      rcnt_in        = rcnt_ff;
      win_ctrl       = '0;
      push_en        = 1'b0;
      push_byte      = head_byte;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_bvalid_in  = rsp_bvalid_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_count_in   = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               byte_in = req_tdata;
               eos_in  = req_tlast;
               if ((plen == '0) || stopped_ff || limit_hit) begin
                  tail_in  = 1'b1;
                  state_in = ST_FLUSH;
               end else begin
                  if (fill_full) begin
                     push_en   = 1'b1;
                     push_byte = req_tdata;
                  end else begin
                     win_ctrl.load = 1'b1;
                  end
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (fill_zero) begin
               state_in = ST_FINISH;
            end else if ((int'(fill) == int'(plen)) && all_match) begin
               win_ctrl.clear = 1'b1;
               match_count_in = count_inc;
               if (hit_after) begin
                  stopped_in = 1'b1;
               end
               rcnt_in  = '0;
               state_in = ST_REPL;
            end else if ((int'(fill) < int'(plen)) && all_match) begin
               state_in = ST_FINISH;
            end else if (anchored_mode_ff) begin
               stopped_in = 1'b1;
               tail_in    = 1'b0;
               state_in   = ST_FLUSH;
            end else begin
               push_en        = 1'b1;
               win_ctrl.shift = 1'b1;
            end
         end
         ST_REPL: begin
            if (rcnt_ff < rlen) begin
               push_en   = 1'b1;
               push_byte = replacement_bytes_ff[{rcnt_ff[2:0], 3'b000} +: 8];
               rcnt_in   = rcnt_ff + srs_pkg::LEN_W'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FLUSH: begin
            if (!fill_zero) begin
               push_en        = 1'b1;
               win_ctrl.shift = 1'b1;
            end else begin
               if (tail_ff) begin
                  push_en   = 1'b1;
                  push_byte = byte_ff;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (eos_ff && !fill_zero) begin
               push_en        = 1'b1;
               win_ctrl.shift = 1'b1;
            end else begin
               snap_in = match_count_ff;
               if (eos_ff) begin
                  match_count_in = '0;
                  stopped_in     = 1'b0;
               end
               rd_in    = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               if (rd_ff < wr_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_byte_in   = queue_ff[rd_ff[QAW-1:0]];
                  rsp_bvalid_in = 1'b1;
                  rsp_last_in   = q_last;
                  rsp_done_in   = q_last && eos_ff;
                  rsp_count_in  = snap_ff;
                  rd_in         = rd_ff + (QAW + 1)'(1);
                  if (q_last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  if (eos_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_byte_in   = '0;
                     rsp_bvalid_in = 1'b0;
                     rsp_last_in   = 1'b1;
                     rsp_done_in   = 1'b1;
                     rsp_count_in  = snap_ff;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result queue fill pointer, emptied when the queue has drained
   always_comb begin
      wr_in = wr_ff;
      if (push_en) begin
         wr_in = wr_ff + (QAW + 1)'(1);
      end else if ((state_ff == ST_DRAIN) && (state_in == ST_IDLE)) begin
         wr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         queue_ff[wr_ff[QAW-1:0]] <= push_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         match_count_ff <= '0;
         stopped_ff     <= 1'b0;
         wr_ff          <= '0;
         rd_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         match_count_ff <= match_count_in;
         stopped_ff     <= stopped_in;
         wr_ff          <= wr_in;
         rd_ff          <= rd_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff       <= snap_in;
      byte_ff       <= byte_in;
      eos_ff        <= eos_in;
      tail_ff       <= tail_in;
      rcnt_ff       <= rcnt_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_done_ff, rsp_bvalid_ff};

endmodule

// File: tb/sv/substring_replace_stream_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for substring_replace_stream_core with directed and random strings
module substring_replace_stream_core_tb;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } src_byte_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last_of_run;
      logic        string_done;
      logic [15:0] replacements;
   } out_byte_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata = '0;   // [7:0] in_byte
   logic                       req_tlast = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [23:0]                rsp_tdata;        // [7:0] out_byte, [23:8] replacements
   logic                       rsp_tlast;
   logic [1:0]                 rsp_tuser;        // [0] byte_valid, [1] string_done
   logic                       csr_wen = 1'b0;
   logic [srs_pkg::CSR_AW-1:0] csr_index = '0;
   logic [srs_pkg::CSR_DW-1:0] csr_wdata = '0;

   src_byte_type  source_q[$];
   out_byte_type  predicted_out_q[$];
   logic [7:0]    step_out_q[$];

   // register copies and match state
   logic [63:0] pat_word = '0;
   logic [63:0] repl_word = '0;
   logic [3:0]  pat_len = '0;
   logic [3:0]  repl_len = '0;
   logic [15:0] lim_count = '0;
   logic        lim_en = 1'b0;
   logic        anchored = 1'b0;
   logic [7:0]  win [srs_pkg::PATTERN_MAX_DEF];
   int          win_fill = 0;
   int          match_total = 0;
   logic        stopped = 1'b0;

   int error_count = 0;
   int items_pushed = 0;
   bit req_fire = 1'b0;
   bit idle_enable = 1'b1;
   bit hold_request = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;

   substring_replace_stream_core DUT (.*);

   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("substring_replace_stream_core_tb: done, errors");
      $finish;
   end

   function automatic int clamp_len(logic [3:0] len);
      return (len > srs_pkg::LEN_CAP) ? srs_pkg::LEN_CAP : int'(len);
   endfunction

   function automatic bit limit_reached();
      return lim_en && match_total >= lim_count;
   endfunction

   function automatic bit window_is_prefix(int plen);
      if (win_fill > plen) return 1'b0;
      for (int i = 0; i < win_fill; i++) begin
         if (win[i] != pat_word[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void flush_window();
      for (int i = 0; i < win_fill; i++) step_out_q.push_back(win[i]);
      win_fill = 0;
   endfunction

   function automatic void predict_replace(logic [7:0] b, logic eos);
      int           plen;
      int           rlen;
      int           n;
      bit           settled;
      logic [15:0]  snap;
      out_byte_type r;
      plen = clamp_len(pat_len);
      rlen = clamp_len(repl_len);
      step_out_q.delete();
      if (plen == 0 || stopped || limit_reached()) begin
         flush_window();
         step_out_q.push_back(b);
      end else begin
         if (win_fill < srs_pkg::PATTERN_MAX_DEF) begin
            win[win_fill] = b;
            win_fill++;
         end else begin
            step_out_q.push_back(b);
         end
         settled = 1'b0;
         while (win_fill > 0 && !settled) begin
            if (win_fill == plen && window_is_prefix(plen)) begin
               for (int i = 0; i < rlen; i++) step_out_q.push_back(repl_word[8*i +: 8]);
               win_fill = 0;
               if (match_total < 16'hFFFF) match_total++;
               if (limit_reached()) stopped = 1'b1;
               settled = 1'b1;
            end else if (win_fill < plen && window_is_prefix(plen)) begin
               settled = 1'b1;
            end else if (anchored) begin
               stopped = 1'b1;
               flush_window();
               settled = 1'b1;
            end else begin
               step_out_q.push_back(win[0]);
               for (int i = 1; i < win_fill; i++) win[i-1] = win[i];
               win_fill--;
            end
         end
      end
      if (eos) flush_window();
      snap = match_total[15:0];
      if (eos) begin
         match_total = 0;
         stopped = 1'b0;
      end
      n = step_out_q.size() > srs_pkg::QUEUE_DEPTH ? srs_pkg::QUEUE_DEPTH : step_out_q.size();
      if (n == 0 && eos) begin
         r = '{out_byte: 8'h00, byte_valid: 1'b0, last_of_run: 1'b1, string_done: 1'b1,
               replacements: snap};
         predicted_out_q.push_back(r);
      end
      for (int k = 0; k < n; k++) begin
         r.out_byte = step_out_q[k];
         r.byte_valid = 1'b1;
         r.last_of_run = (k == n - 1);
         r.string_done = (k == n - 1) && eos;
         r.replacements = snap;
         predicted_out_q.push_back(r);
      end
   endfunction

   function automatic void check_field(string name, logic [15:0] expv, logic [15:0] got);
      if (expv !== got) begin
         $error("%s: expected %0h, got %0h", name, expv, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      out_byte_type want;
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire) begin
         predict_replace(source_q[0].data, source_q[0].last);
         void'(source_q.pop_front());
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_out_q.size() == 0) begin
            $error("out_byte: expected no transfer, got %0h", rsp_tdata[7:0]);
            error_count++;
         end else begin
            want = predicted_out_q.pop_front();
            check_field("out_byte", 16'(want.out_byte), 16'(rsp_tdata[7:0]));
            check_field("byte_valid", 16'(want.byte_valid), 16'(rsp_tuser[0]));
            check_field("last_of_run", 16'(want.last_of_run), 16'(rsp_tlast));
            check_field("string_done", 16'(want.string_done), 16'(rsp_tuser[1]));
            check_field("replacements", want.replacements, rsp_tdata[23:8]);
         end
      end
   end

   always @(negedge clock) begin
      if (!req_tvalid || req_fire) begin
         if (send_gap == 0 && idle_enable && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 19);
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (source_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= source_q[0].data;
            req_tlast <= source_q[0].last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
         recv_gap = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic csr_write(logic [srs_pkg::CSR_AW-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         srs_pkg::CSR_PATTERN_BYTES:      pat_word = val;
         srs_pkg::CSR_PATTERN_LENGTH:     pat_len = val[3:0];
         srs_pkg::CSR_REPLACEMENT_BYTES:  repl_word = val;
         srs_pkg::CSR_REPLACEMENT_LENGTH: repl_len = val[3:0];
         srs_pkg::CSR_LIMIT_COUNT:        lim_count = val[15:0];
         srs_pkg::CSR_LIMIT_ENABLE:       lim_en = val[0];
         srs_pkg::CSR_ANCHORED_MODE:      anchored = val[0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(logic [63:0] pw, logic [3:0] pl, logic [63:0] rw,
                                logic [3:0] rl, logic [15:0] lc, logic le, logic am);
      csr_write(srs_pkg::CSR_PATTERN_BYTES, pw);
      csr_write(srs_pkg::CSR_PATTERN_LENGTH, 64'(pl));
      csr_write(srs_pkg::CSR_REPLACEMENT_BYTES, rw);
      csr_write(srs_pkg::CSR_REPLACEMENT_LENGTH, 64'(rl));
      csr_write(srs_pkg::CSR_LIMIT_COUNT, 64'(lc));
      csr_write(srs_pkg::CSR_LIMIT_ENABLE, 64'(le));
      csr_write(srs_pkg::CSR_ANCHORED_MODE, 64'(am));
   endtask

   task automatic random_setting();
      logic [7:0]  a0;
      logic [7:0]  a1;
      logic [63:0] pw;
      a0 = 8'($urandom_range(0, 255));
      a1 = a0 ^ (8'h01 << $urandom_range(0, 7));
      for (int i = 0; i < 8; i++) begin
         if ($urandom_range(0, 3) == 0) pw[8*i +: 8] = 8'($urandom_range(0, 255));
         else pw[8*i +: 8] = $urandom_range(0, 1) ? a1 : a0;
      end
      apply_setting(pw,
                    $urandom_range(0, 9) == 0 ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(1, 8)),
                    {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                    $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4)),
                    $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
   endtask

   task automatic wait_drained();
      while (source_q.size() > 0 || predicted_out_q.size() > 0) @(negedge clock);
      repeat (64) @(negedge clock);
   endtask

   function automatic void push_src(logic [7:0] data, logic last);
      source_q.push_back('{data, last});
      items_pushed++;
   endfunction

   function automatic void push_text(string s, bit eos);
      for (int i = 0; i < s.len(); i++) push_src(s[i], eos && i == s.len() - 1);
   endfunction

   // mostly pattern pieces with random bytes mixed in, sometimes pure noise
   task automatic push_random_string();
      logic [7:0] text[$];
      int         len;
      int         plen;
      int         pick;
      int         k;
      bit         noise;
      len = $urandom_range(1, 24);
      plen = clamp_len(pat_len);
      if (plen == 0) plen = 1;
      noise = ($urandom_range(0, 6) == 0);
      while (text.size() < len) begin
         pick = noise ? 9 : $urandom_range(0, 9);
         if (pick < 4) begin
            for (int i = 0; i < plen; i++) text.push_back(pat_word[8*i +: 8]);
         end else if (pick < 6) begin
            k = $urandom_range(1, plen);
            for (int i = 0; i < k; i++) text.push_back(pat_word[8*i +: 8]);
         end else if (pick < 8) begin
            k = $urandom_range(0, plen - 1);
            text.push_back(pat_word[8*k +: 8]);
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      for (int i = 0; i < text.size(); i++) push_src(text[i], i == text.size() - 1);
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // reset values: pattern length zero, bytes pass through
      push_src(8'h00, 1'b0);
      push_src(8'hFF, 1'b1);
      wait_drained();

      apply_setting(64'h6261, 4'd2, 64'h5A5958, 4'd3, 16'd0, 1'b0, 1'b0);
      push_text("aabxa", 1'b1);
      wait_drained();

      // deleting replacement with a limit of one
      apply_setting(64'h6261, 4'd2, 64'h5A5958, 4'd0, 16'd1, 1'b1, 1'b0);
      push_text("ab", 1'b1);
      push_text("abab", 1'b1);
      wait_drained();

      apply_setting(64'h6261, 4'd2, 64'h5A5958, 4'd3, 16'd0, 1'b0, 1'b1);
      push_text("ababxab", 1'b1);
      wait_drained();

      // pattern shortened while a partial match sits in the window
      apply_setting(64'h636261, 4'd3, '1, 4'd15, 16'd0, 1'b0, 1'b0);
      push_text("ab", 1'b0);
      wait_drained();
      csr_write(srs_pkg::CSR_PATTERN_LENGTH, 64'd1);
      push_text("ca", 1'b1);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 0) apply_setting('1, 4'd15, '0, 4'd8, 16'hFFFF, 1'b1, 1'b0);
         else if (phase == 1) apply_setting('0, 4'd1, {$urandom, $urandom}, 4'd15, 16'd0,
                                            1'b0, 1'b0);
         else random_setting();
         if (phase == 3) hold_request = 1'b1;
         if (phase == 7) idle_enable = 1'b0;
         items_pushed = 0;
         while (items_pushed < 45) push_random_string();
         wait_drained();
      end

      if (error_count == 0) begin
         $display("substring_replace_stream_core_tb: done, clean");
      end else begin
         $display("substring_replace_stream_core_tb: done, errors");
      end
      $finish;
   end

endmodule
